### rtl/core/lfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the line follower steering core.
// ----------------------------------------------------------------------------
package lfs_pkg;

   // field widths
   localparam int LEVEL_W   = 12;
   localparam int SPEED_W   = 16;
   localparam int GAIN_W    = 8;
   localparam int PROD_W    = GAIN_W + LEVEL_W;
   localparam int CSR_IDX_W = 3;

   // request and response beat layout
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // decoupling queue
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_RST   = 8'd1;
   localparam logic [LEVEL_W-1:0] BLACK_RST  = 12'd4095;
   localparam logic [LEVEL_W-1:0] WHITE_RST  = 12'd200;
   localparam logic [SPEED_W-1:0] MIN_RST    = 16'd0;
   localparam logic [SPEED_W-1:0] OFF_RST    = 16'd0;
   localparam logic [SPEED_W-1:0] TICKS_RST  = 16'd10;

   typedef enum logic [1:0] {
      POS_OFF    = 2'd0,
      POS_LEFT   = 2'd1,
      POS_RIGHT  = 2'd2,
      POS_CENTER = 2'd3
   } pos_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN        = 3'd0,
      CSR_BLACK       = 3'd1,
      CSR_WHITE       = 3'd2,
      CSR_INNER_DRIVE = 3'd3,
      CSR_SLOW_LIMIT  = 3'd4,
      CSR_REC_TICKS   = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain;
      logic [LEVEL_W-1:0] black_level;
      logic [LEVEL_W-1:0] white_max;
      logic [SPEED_W-1:0] inner_drive;
      logic [SPEED_W-1:0] slow_limit;
      logic [SPEED_W-1:0] recovery_ticks;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type             op;
      pos_type            pos;
      logic               left_gt;
      logic [SPEED_W-1:0] speed;
      logic [SPEED_W-1:0] ld;
      logic [SPEED_W-1:0] rd;
   } qent_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [Q_CNT_W-1:0] count;
   } qstat_type;

endpackage

### rtl/core/line_follow_steering_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_steering_core
// Two-sensor proportional line follower: wheel drives from sensor samples.
// ----------------------------------------------------------------------------
// Usage
//  req channel: one beat per navigation sample (tuser op = 0) or timer tick
//  (tuser op = 1). A sample gives one rsp beat, a tick gives none and only
//  advances the saturating recovery counter.
//  rsp channel: left and right drive, line position and the restart flag.
//  csr channel: register writes by index, always ready; write only while
//  the core is idle.
// Throughput
//  one beat per cycle while rsp is not stalled; a sample passes the product
//  stage, the queue and the result register on its way to rsp.
// Reset
//  registers return to their defaults, position state to centered with no
//  recovery turn and the recovery counter to zero; queue and outputs empty.
// Back-pressure
//  a stalled rsp holds the result register; four entries collect in the
//  queue and one in the product stage before req_tready drops. Ticks keep
//  draining from the queue head while the result waits.
// ----------------------------------------------------------------------------
module line_follow_steering_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // left_level[11:0], right_level[23:12], speed[39:24]
   input  logic [lfs_pkg::REQ_DATA_W-1:0]        req_tdata,
   // op[0]
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // left_drive[15:0], right_drive[31:16], position[33:32],
   // restart_timer[34], zeros[39:35]
   output logic [lfs_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lfs_pkg::SPEED_W-1:0]           csr_data
);

   lfs_pkg::cfg_type   cfg_ff;
   lfs_pkg::qstat_type q_stat;
   lfs_pkg::qent_type  q_wdata, q_head;
   logic               q_push, q_pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain           <= lfs_pkg::GAIN_RST;
         cfg_ff.black_level    <= lfs_pkg::BLACK_RST;
         cfg_ff.white_max      <= lfs_pkg::WHITE_RST;
         cfg_ff.inner_drive    <= lfs_pkg::MIN_RST;
         cfg_ff.slow_limit     <= lfs_pkg::OFF_RST;
         cfg_ff.recovery_ticks <= lfs_pkg::TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (lfs_pkg::csr_idx_type'(csr_index))
            lfs_pkg::CSR_GAIN:        cfg_ff.gain <= csr_data[lfs_pkg::GAIN_W-1:0];
            lfs_pkg::CSR_BLACK:       cfg_ff.black_level <= csr_data[lfs_pkg::LEVEL_W-1:0];
            lfs_pkg::CSR_WHITE:       cfg_ff.white_max <= csr_data[lfs_pkg::LEVEL_W-1:0];
            lfs_pkg::CSR_INNER_DRIVE: cfg_ff.inner_drive <= csr_data;
            lfs_pkg::CSR_SLOW_LIMIT:  cfg_ff.slow_limit <= csr_data;
            lfs_pkg::CSR_REC_TICKS:   cfg_ff.recovery_ticks <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // front: products and classification
   lfs_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // decoupling queue
   lfs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .head  (q_head),
      .stat  (q_stat)
   );

   // back: steering state and result register
   lfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // queue never holds more than its depth
   a_q_count : assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= lfs_pkg::Q_CNT_W'(lfs_pkg::Q_DEPTH))
      else $error("queue count above depth");

   // a stalled result is never overwritten by a sample
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !q_stat.empty && q_head.op == lfs_pkg::OP_SAMPLE)
      |-> !q_pop)
      else $error("result register overrun");

   // restart flag only when off the line
   a_restart_off : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[34]) |-> (rsp_tdata[33:32] == lfs_pkg::POS_OFF))
      else $error("restart flag with line in view");

   // queue never pushed while full
   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("push into full queue");

endmodule

### rtl/core/lfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_front
// Accepts request beats, forms the proportional corrections and classifies
// the sensors, then pushes one entry per beat into the decoupling queue.
// ----------------------------------------------------------------------------
module lfs_front #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lfs_pkg::cfg_type                  cfg,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // left_level[11:0], right_level[23:12], speed[39:24]
   input  logic [lfs_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op[0]
   input  logic                              req_tuser,
   input  lfs_pkg::qstat_type                q_stat,
   output logic                              q_push,
   output lfs_pkg::qent_type                 q_wdata
);

   localparam int LW = lfs_pkg::LEVEL_W;
   localparam int SW = lfs_pkg::SPEED_W;
   localparam int PW = lfs_pkg::PROD_W;
   localparam logic [LW-1:0] LVL_MASK =
      (SAMPLE_BITS >= LW) ? {LW{1'b1}} : LW'((1 << SAMPLE_BITS) - 1);

   logic [LW-1:0] lvl_l, lvl_r, black, white;
   logic [LW:0]   diff_l, diff_r;
   logic [PW-1:0] prod_l_in, prod_r_in;
   logic [SW-1:0] speed_in;
   lfs_pkg::pos_type pos_in;
   logic          take;

   logic                  s1_vld_ff;
   lfs_pkg::op_type       s1_op_ff;
   logic [SW-1:0]         s1_speed_ff;
   logic [PW-1:0]         s1_prod_l_ff, s1_prod_r_ff;
   lfs_pkg::pos_type      s1_pos_ff;
   logic                  s1_lgt_ff;

   logic [SW-1:0] corr_l, corr_r;

   // levels and level registers taken in the low sample bits
   assign lvl_l    = req_tdata[LW-1:0] & LVL_MASK;
   assign lvl_r    = req_tdata[2*LW-1:LW] & LVL_MASK;
   assign speed_in = req_tdata[2*LW+SW-1:2*LW];
   assign black    = cfg.black_level & LVL_MASK;
   assign white    = cfg.white_max & LVL_MASK;

   // error against black level, negative error gives no correction
   assign diff_l    = {1'b0, black} - {1'b0, lvl_l};
   assign diff_r    = {1'b0, black} - {1'b0, lvl_r};
   assign prod_l_in = diff_l[LW] ? '0 : PW'(cfg.gain) * PW'(diff_l[LW-1:0]);
   assign prod_r_in = diff_r[LW] ? '0 : PW'(cfg.gain) * PW'(diff_r[LW-1:0]);

   // sensor classification
   always_comb begin
      if (lvl_l < white && lvl_r < white) begin
         pos_in = lfs_pkg::POS_OFF;
      end else if (lvl_l < white) begin
         pos_in = lfs_pkg::POS_LEFT;
      end else if (lvl_r < white) begin
         pos_in = lfs_pkg::POS_RIGHT;
      end else begin
         pos_in = lfs_pkg::POS_CENTER;
      end
   end

   // stage moves on whenever the queue has room
   assign q_push     = s1_vld_ff && !q_stat.full;
   assign req_tready = !s1_vld_ff || !q_stat.full;
   assign take       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (take) begin
         s1_vld_ff <= 1'b1;
      end else if (q_push) begin
         s1_vld_ff <= 1'b0;
      end
   end

   // product stage payload
   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff     <= lfs_pkg::op_type'(req_tuser);
         s1_speed_ff  <= speed_in;
         s1_prod_l_ff <= prod_l_in;
         s1_prod_r_ff <= prod_r_in;
         s1_pos_ff    <= pos_in;
         s1_lgt_ff    <= lvl_l > lvl_r;
      end
   end

   // clamp corrections to speed and take them off the opposite wheel
   assign corr_l = (s1_prod_l_ff > PW'(s1_speed_ff)) ? s1_speed_ff : s1_prod_l_ff[SW-1:0];
   assign corr_r = (s1_prod_r_ff > PW'(s1_speed_ff)) ? s1_speed_ff : s1_prod_r_ff[SW-1:0];

   always_comb begin
      q_wdata.op      = s1_op_ff;
      q_wdata.pos     = s1_pos_ff;
      q_wdata.left_gt = s1_lgt_ff;
      q_wdata.speed   = s1_speed_ff;
      q_wdata.rd      = s1_speed_ff - corr_l;
      q_wdata.ld      = s1_speed_ff - corr_r;
   end

endmodule

### rtl/core/lfs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_queue
// Short register queue between the front and back halves of the core.
// ----------------------------------------------------------------------------
module lfs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  lfs_pkg::qent_type  wdata,
   input  logic               pop,
   output lfs_pkg::qent_type  head,
   output lfs_pkg::qstat_type stat
);

   localparam int PTR_W = lfs_pkg::Q_PTR_W;
   localparam int CNT_W = lfs_pkg::Q_CNT_W;

   lfs_pkg::qent_type  mem_ff [lfs_pkg::Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   // occupancy tracking
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(lfs_pkg::Q_DEPTH));

endmodule

### rtl/core/lfs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_back
// Applies the steering state (last side, recovery turn, tick counter) to
// each queued entry and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module lfs_back (
   input  logic                              clock,
   input  logic                              reset,
   input  lfs_pkg::cfg_type                  cfg,
   input  lfs_pkg::qstat_type                q_stat,
   input  lfs_pkg::qent_type                 q_head,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // left_drive[15:0], right_drive[31:16], position[33:32],
   // restart_timer[34], zeros[39:35]
   output logic [lfs_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int SW = lfs_pkg::SPEED_W;

   lfs_pkg::pos_type last_pos_ff, last_pos_in;
   lfs_pkg::pos_type rec_side_ff, rec_side_in;
   logic [SW-1:0]    rec_cnt_ff, rec_cnt_in;

   logic          rsp_vld_ff;
   logic [lfs_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [SW-1:0] ld, rd;
   logic          restart;
   logic          hold_rec;
   logic          out_free;

   // output register free when empty or being drained
   assign out_free = !rsp_vld_ff || rsp_tready;
   assign q_pop    = !q_stat.empty && (q_head.op == lfs_pkg::OP_TICK || out_free);
   assign hold_rec = rec_cnt_ff < cfg.recovery_ticks;

   // steering decision
   always_comb begin
      last_pos_in = last_pos_ff;
      rec_side_in = rec_side_ff;
      rec_cnt_in  = rec_cnt_ff;
      ld          = q_head.ld;
      rd          = q_head.rd;
      restart     = 1'b0;
      if (q_head.op == lfs_pkg::OP_TICK) begin
         if (rec_cnt_ff != '1) begin
            rec_cnt_in = rec_cnt_ff + SW'(1);
         end
      end else if (q_head.pos == lfs_pkg::POS_OFF) begin
         // lost the line: steer toward the side last seen; with no side seen, flag a restart
         rec_cnt_in = '0;
         if (last_pos_ff == lfs_pkg::POS_RIGHT) begin
            rec_side_in = lfs_pkg::POS_RIGHT;
            rd          = q_head.speed;
            ld          = cfg.inner_drive;
         end else if (last_pos_ff == lfs_pkg::POS_LEFT) begin
            rec_side_in = lfs_pkg::POS_LEFT;
            rd          = cfg.inner_drive;
            ld          = q_head.speed;
         end else begin
            restart = 1'b1;
            rd      = cfg.inner_drive;
            ld      = q_head.speed;
         end
      end else if (rec_side_ff == lfs_pkg::POS_LEFT && hold_rec) begin
         rd = q_head.speed;
         ld = cfg.inner_drive;
      end else if (rec_side_ff == lfs_pkg::POS_RIGHT && hold_rec) begin
         rd = cfg.inner_drive;
         ld = q_head.speed;
      end else begin
         // both wheels too slow: turn toward the stronger sensor
         if (cfg.slow_limit > q_head.rd && cfg.slow_limit > q_head.ld) begin
            if (q_head.left_gt) begin
               rd = q_head.speed;
               ld = cfg.inner_drive;
            end else begin
               rd = cfg.inner_drive;
               ld = q_head.speed;
            end
         end
         last_pos_in = q_head.pos;
         rec_side_in = lfs_pkg::POS_CENTER;
      end
   end

   // steering state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff <= lfs_pkg::POS_CENTER;
         rec_side_ff <= lfs_pkg::POS_CENTER;
         rec_cnt_ff  <= '0;
      end else if (q_pop) begin
         last_pos_ff <= last_pos_in;
         rec_side_ff <= rec_side_in;
         rec_cnt_ff  <= rec_cnt_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (q_pop && q_head.op == lfs_pkg::OP_SAMPLE) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.op == lfs_pkg::OP_SAMPLE) begin
         rsp_data_ff <= {5'b0, restart, q_head.pos, rd, ld};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
